[design/irc_mft_pkg.sv]
// ----------------------------------------------------------------------------
// irc_mft_pkg
// Shared types and constants of the IRC message field tagger: field kinds,
// special byte codes, and the result and queue entry formats.
// ----------------------------------------------------------------------------
package irc_mft_pkg;

  // Defaults for top-level parameters
  localparam int MAX_PARAMS_DEF  = 15;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Field kinds
  localparam logic [2:0] K_NICK     = 3'd0;
  localparam logic [2:0] K_USER     = 3'd1;
  localparam logic [2:0] K_HOST     = 3'd2;
  localparam logic [2:0] K_COMMAND  = 3'd3;
  localparam logic [2:0] K_MIDDLE   = 3'd4;
  localparam logic [2:0] K_TRAILING = 3'd5;
  localparam logic [2:0] K_END      = 3'd6;

  // Special bytes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // One tagged result
  typedef struct packed {
    logic [2:0] field_kind;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_start;
    logic [3:0] param_number;
    logic       param_overflow;
  } res_t;

  // One queue entry: a result, optionally preceded by a trailing space
  typedef struct packed {
    res_t res;
    logic pre_space;
  } pkt_t;

endpackage

[design/irc_message_field_tagger.sv]
// An accepted byte's result is written into the queue, then loaded into the output register,
// from which it is presented.
// Throughput: one byte per cycle while the queue is not full; whitespace bytes yield nothing,
// a byte that follows a gap in the trailing parameter yields a space result and then its own.
// The queue depth sets how long the input keeps taking bytes while the output stalls.
// Reset: synchronous, active low; clears parser state, queue and output valid.
// ----------------------------------------------------------------------------
// irc_message_field_tagger
// Tags each content byte of an IRC line with its field: prefix parts,
// command, numbered middle parameters, trailing parameter and end marker.
// ----------------------------------------------------------------------------
module irc_message_field_tagger #(
  parameter int MAX_PARAMS  = irc_mft_pkg::MAX_PARAMS_DEF,
  parameter int QUEUE_DEPTH = irc_mft_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] byte_valid, [9] token_start,
                                  // [13:10] param_number, [14] param_overflow, [15] zero
  output logic [2:0]  out_tuser,  // [2:0] field_kind
  output logic        out_tlast   // last result of the input byte
);
  import irc_mft_pkg::*;

  logic q_push, q_full, q_pop, q_valid;
  pkt_t q_in, q_out;
  res_t res;

  irc_mft_front #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  irc_mft_queue #(
    .WIDTH ($bits(pkt_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_out)
  );

  irc_mft_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res),
    .out_last   (out_tlast)
  );

  // Pack result fields
  assign out_tdata = {1'b0, res.param_overflow, res.param_number, res.token_start,
                      res.byte_valid, res.out_byte};
  assign out_tuser = res.field_kind;

endmodule

[design/irc_mft_queue.sv]
// ----------------------------------------------------------------------------
// irc_mft_queue
// Small register FIFO that decouples the classifier from the emitter.
// ----------------------------------------------------------------------------
module irc_mft_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count exceeds depth");
`endif

endmodule

[design/irc_mft_front.sv]
// ----------------------------------------------------------------------------
// irc_mft_front
// Byte classifier: tracks the message phase and produces at most one queue
// entry per accepted byte.
// ----------------------------------------------------------------------------
module irc_mft_front #(
  parameter int MAX_PARAMS = irc_mft_pkg::MAX_PARAMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              q_full,
  output logic              q_push,
  output irc_mft_pkg::pkt_t q_data
);
  import irc_mft_pkg::*;

  localparam logic [3:0] LIMIT = 4'((MAX_PARAMS > 15) ? 15 : MAX_PARAMS);

  typedef enum logic [2:0] {
    PH_START, PH_PREFIX, PH_COMMAND, PH_PARAMS, PH_TRAILING
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [1:0] prefix_part_r, prefix_part_nxt;
  logic       in_word_r, in_word_nxt;
  logic       cr_pending_r, cr_pending_nxt;
  logic       space_pending_r, space_pending_nxt;
  logic [3:0] param_count_r, param_count_nxt;
  logic       param_any_r, param_any_nxt;
  logic       overflow_seen_r, overflow_seen_nxt;

  logic       accept;
  logic       has_res;
  logic       is_end;
  logic       is_ws;
  logic [7:0] b;
  pkt_t       pkt;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign is_ws     = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  assign is_end    = (b == CH_LF) && cr_pending_r;
  assign q_push    = accept && has_res;
  assign q_data    = pkt;

  // Classify byte and compute next state
  always_comb begin
    phase_nxt         = phase_r;
    prefix_part_nxt   = prefix_part_r;
    in_word_nxt       = in_word_r;
    cr_pending_nxt    = cr_pending_r;
    space_pending_nxt = space_pending_r;
    param_count_nxt   = param_count_r;
    param_any_nxt     = param_any_r;
    overflow_seen_nxt = overflow_seen_r;
    has_res           = 1'b0;
    pkt               = '0;

    if (is_end) begin
      // End marker, then return to the start of message
      has_res                  = 1'b1;
      pkt.res.field_kind       = K_END;
      pkt.res.token_start      = 1'b1;
      pkt.res.param_number     = param_count_r;
      pkt.res.param_overflow   = overflow_seen_r;
      phase_nxt         = PH_START;
      prefix_part_nxt   = K_NICK[1:0];
      in_word_nxt       = 1'b0;
      cr_pending_nxt    = 1'b0;
      space_pending_nxt = 1'b0;
      param_count_nxt   = '0;
      param_any_nxt     = 1'b0;
      overflow_seen_nxt = 1'b0;
    end else begin
      cr_pending_nxt = (b == CH_CR);
      if (is_ws) begin
        // Close the current word; note a gap inside the trailing parameter
        case (phase_r)
          PH_PREFIX:   phase_nxt = PH_COMMAND;
          PH_COMMAND:  if (in_word_r) phase_nxt = PH_PARAMS;
          PH_TRAILING: space_pending_nxt = 1'b1;
          default:     phase_nxt = phase_r;
        endcase
        in_word_nxt = 1'b0;
      end else begin
        pkt.res.out_byte   = b;
        pkt.res.byte_valid = 1'b1;
        case (phase_r)
          PH_START: begin
            if (b == CH_COLON) begin
              phase_nxt       = PH_PREFIX;
              prefix_part_nxt = K_NICK[1:0];
              in_word_nxt     = 1'b0;
            end else begin
              phase_nxt           = PH_COMMAND;
              has_res             = 1'b1;
              pkt.res.field_kind  = K_COMMAND;
              pkt.res.token_start = 1'b1;
              in_word_nxt         = 1'b1;
            end
          end
          PH_PREFIX: begin
            if (b == CH_COLON) begin
              prefix_part_nxt = K_NICK[1:0];
              in_word_nxt     = 1'b0;
            end else if (b == CH_BANG) begin
              prefix_part_nxt = K_USER[1:0];
              in_word_nxt     = 1'b0;
            end else if (b == CH_AT) begin
              prefix_part_nxt = K_HOST[1:0];
              in_word_nxt     = 1'b0;
            end else begin
              has_res             = 1'b1;
              pkt.res.field_kind  = {1'b0, prefix_part_r};
              pkt.res.token_start = !in_word_r;
              in_word_nxt         = 1'b1;
            end
          end
          PH_COMMAND: begin
            has_res             = 1'b1;
            pkt.res.field_kind  = K_COMMAND;
            pkt.res.token_start = !in_word_r;
            in_word_nxt         = 1'b1;
          end
          PH_PARAMS: begin
            has_res = 1'b1;
            if (!in_word_r) begin
              // Number the new parameter, saturating at the limit
              if (!param_any_r) begin
                param_any_nxt   = 1'b1;
                param_count_nxt = '0;
              end else if (param_count_r < LIMIT) begin
                param_count_nxt = param_count_r + 1'b1;
              end else begin
                overflow_seen_nxt = 1'b1;
              end
              pkt.res.param_number   = param_count_nxt;
              pkt.res.param_overflow = overflow_seen_nxt;
              pkt.res.token_start    = 1'b1;
              if (b == CH_COLON) begin
                phase_nxt          = PH_TRAILING;
                space_pending_nxt  = 1'b0;
                pkt.res.field_kind = K_TRAILING;
                pkt.res.out_byte   = '0;
                pkt.res.byte_valid = 1'b0;
              end else begin
                pkt.res.field_kind = K_MIDDLE;
                in_word_nxt        = 1'b1;
              end
            end else begin
              pkt.res.field_kind     = K_MIDDLE;
              pkt.res.param_number   = param_count_r;
              pkt.res.param_overflow = overflow_seen_r;
            end
          end
          PH_TRAILING: begin
            has_res                = 1'b1;
            pkt.pre_space          = space_pending_r;
            pkt.res.field_kind     = K_TRAILING;
            pkt.res.param_number   = param_count_r;
            pkt.res.param_overflow = overflow_seen_r;
            space_pending_nxt      = 1'b0;
            in_word_nxt            = 1'b1;
          end
          default: begin
            has_res = 1'b0;
          end
        endcase
      end
    end
  end

  // Hold parser state; update on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_START;
      prefix_part_r   <= K_NICK[1:0];
      in_word_r       <= 1'b0;
      cr_pending_r    <= 1'b0;
      space_pending_r <= 1'b0;
      param_count_r   <= '0;
      param_any_r     <= 1'b0;
      overflow_seen_r <= 1'b0;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      prefix_part_r   <= prefix_part_nxt;
      in_word_r       <= in_word_nxt;
      cr_pending_r    <= cr_pending_nxt;
      space_pending_r <= space_pending_nxt;
      param_count_r   <= param_count_nxt;
      param_any_r     <= param_any_nxt;
      overflow_seen_r <= overflow_seen_nxt;
    end
  end

`ifndef SYNTHESIS
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_end) |=> (phase_r == PH_START && param_count_r == '0
                            && !overflow_seen_r && !param_any_r))
    else $error("state not cleared after end of message");
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    param_count_r <= LIMIT)
    else $error("parameter index above limit");
`endif

endmodule

[design/irc_mft_back.sv]
// ----------------------------------------------------------------------------
// irc_mft_back
// Result emitter: drains queue entries into the output register, splitting
// an entry with a pending trailing space into two results.
// ----------------------------------------------------------------------------
module irc_mft_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  irc_mft_pkg::pkt_t q_data,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output irc_mft_pkg::res_t out_res,
  output logic              out_last
);
  import irc_mft_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic sp_done_r, sp_done_nxt;
  res_t out_res_r, out_res_nxt;
  logic out_last_r, out_last_nxt;
  logic load;

  assign load       = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;
  assign out_last   = out_last_r;

  // Load next result when the output register frees up
  always_comb begin
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    sp_done_nxt   = sp_done_r;
    if (load && q_valid) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = q_data.res;
      if (q_data.pre_space && !sp_done_r) begin
        out_res_nxt.out_byte   = CH_SPACE;
        out_res_nxt.byte_valid = 1'b1;
        out_last_nxt           = 1'b0;
        sp_done_nxt            = 1'b1;
      end else begin
        out_last_nxt = 1'b1;
        sp_done_nxt  = 1'b0;
        q_pop        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sp_done_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sp_done_r   <= sp_done_nxt;
    end
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_space_then_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_last) |=>
      (out_tvalid && out_res.field_kind == K_TRAILING))
    else $error("inserted space not followed by its trailing byte");
  a_space_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_last) |->
      (out_res.out_byte == CH_SPACE && out_res.field_kind == K_TRAILING
       && out_res.byte_valid && !out_res.token_start))
    else $error("non-final result is not a trailing space");
`endif

endmodule

[verif/irc_field_tag_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_field_tag_checker
// Watches both streams of the IRC message field tagger. It keeps its own
// parser state to work out the tags that each accepted byte should produce,
// and compares every result transfer field by field with the oldest tag due.
// ----------------------------------------------------------------------------
module irc_field_tag_checker #(
  parameter int MAX_PARAMS = irc_mft_pkg::MAX_PARAMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,   // [7:0] out_byte, [8] byte_valid, [9] token_start,
                                   // [13:10] param_number, [14] param_overflow, [15] zero
  input  logic [2:0]  out_tuser,   // [2:0] field_kind
  input  logic        out_tlast,
  output int          tags_pending,
  output int          mismatch_count
);
  import irc_mft_pkg::*;

  // Parameter index saturates at the smaller of MAX_PARAMS and the field maximum
  localparam logic [3:0] PARAM_INDEX_MAX = (MAX_PARAMS > 15) ? 4'd15 : 4'(MAX_PARAMS);

  typedef enum logic [2:0] {
    PH_START,
    PH_PREFIX,
    PH_COMMAND,
    PH_PARAMS,
    PH_TRAILING
  } parse_phase_t;

  typedef struct packed {
    res_t res;
    logic last;
  } tag_due_t;

  parse_phase_t phase;
  logic [2:0]   prefix_kind;
  logic         in_word;
  logic         cr_seen;
  logic         space_due;
  logic [3:0]   param_idx;
  logic         param_open;
  logic         overflow_seen;
  tag_due_t     tags_due[$];

  // Return the parser to the start of a message
  task automatic clear_parser();
    phase         = PH_START;
    prefix_kind   = K_NICK;
    in_word       = 1'b0;
    cr_seen       = 1'b0;
    space_due     = 1'b0;
    param_idx     = 4'd0;
    param_open    = 1'b0;
    overflow_seen = 1'b0;
  endtask

  // Parameter number and overflow only apply to middle, trailing and end tags
  function automatic res_t make_tag(input logic [2:0] kind, input logic [7:0] data,
                                    input logic valid, input logic start);
    res_t r;
    logic is_param;
    is_param         = (kind >= K_MIDDLE);
    r.field_kind     = kind;
    r.out_byte       = data;
    r.byte_valid     = valid;
    r.token_start    = start;
    r.param_number   = is_param ? param_idx : 4'd0;
    r.param_overflow = is_param & overflow_seen;
    return r;
  endfunction

  // Advance the parser by one byte and queue the tags it produces
  task automatic tag_rx_byte(input logic [7:0] b);
    res_t made[2];
    int   n;
    int   i;
    n = 0;
    if (b == CH_LF && cr_seen) begin
      made[0] = make_tag(K_END, 8'h00, 1'b0, 1'b1);
      n = 1;
      clear_parser();
    end else begin
      cr_seen = (b == CH_CR);
      if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
        // whitespace closes the current word and never yields a tag
        if (phase == PH_PREFIX) begin
          phase = PH_COMMAND;
        end else if (phase == PH_COMMAND && in_word) begin
          phase = PH_PARAMS;
        end else if (phase == PH_TRAILING) begin
          space_due = 1'b1;
        end
        in_word = 1'b0;
      end else begin
        case (phase)
          PH_START: begin
            if (b == CH_COLON) begin
              phase       = PH_PREFIX;
              prefix_kind = K_NICK;
              in_word     = 1'b0;
            end else begin
              phase   = PH_COMMAND;
              made[n] = make_tag(K_COMMAND, b, 1'b1, 1'b1);
              n++;
              in_word = 1'b1;
            end
          end
          PH_PREFIX: begin
            if (b == CH_COLON || b == CH_BANG || b == CH_AT) begin
              prefix_kind = (b == CH_COLON) ? K_NICK : (b == CH_BANG) ? K_USER : K_HOST;
              in_word     = 1'b0;
            end else begin
              made[n] = make_tag(prefix_kind, b, 1'b1, !in_word);
              n++;
              in_word = 1'b1;
            end
          end
          PH_COMMAND: begin
            made[n] = make_tag(K_COMMAND, b, 1'b1, !in_word);
            n++;
            in_word = 1'b1;
          end
          PH_PARAMS: begin
            if (!in_word) begin
              // a new parameter word: bump the index, saturate, flag overflow
              if (!param_open) begin
                param_open = 1'b1;
                param_idx  = 4'd0;
              end else if (param_idx < PARAM_INDEX_MAX) begin
                param_idx++;
              end else begin
                overflow_seen = 1'b1;
              end
              if (b == CH_COLON) begin
                phase     = PH_TRAILING;
                space_due = 1'b0;
                made[n]   = make_tag(K_TRAILING, 8'h00, 1'b0, 1'b1);
                n++;
              end else begin
                made[n] = make_tag(K_MIDDLE, b, 1'b1, 1'b1);
                n++;
                in_word = 1'b1;
              end
            end else begin
              made[n] = make_tag(K_MIDDLE, b, 1'b1, 1'b0);
              n++;
            end
          end
          PH_TRAILING: begin
            // a whitespace run inside the trailing parameter comes back as one space
            if (space_due) begin
              made[n] = make_tag(K_TRAILING, CH_SPACE, 1'b1, 1'b0);
              n++;
            end
            space_due = 1'b0;
            made[n]   = make_tag(K_TRAILING, b, 1'b1, 1'b0);
            n++;
            in_word   = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
    for (i = 0; i < n; i++) begin
      tags_due.insert(tags_due.size(), tag_due_t'{made[i], (i == n - 1)});
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Predict on input transfers, compare on result transfers
  always @(posedge clk) begin
    tag_due_t due;
    if (!rst_n) begin
      clear_parser();
      tags_due.delete();
      mismatch_count = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        tag_rx_byte(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (tags_due.size() == 0) begin
          $error("result transfer with no tag due: kind %0d, data 0x%h",
                 out_tuser, out_tdata);
          mismatch_count++;
        end else begin
          due = tags_due.pop_front();
          compare_field("field_kind", due.res.field_kind, out_tuser);
          compare_field("out_byte", due.res.out_byte, out_tdata[7:0]);
          compare_field("byte_valid", due.res.byte_valid, out_tdata[8]);
          compare_field("token_start", due.res.token_start, out_tdata[9]);
          compare_field("param_number", due.res.param_number, out_tdata[13:10]);
          compare_field("param_overflow", due.res.param_overflow, out_tdata[14]);
          compare_field("tdata_pad", 0, out_tdata[15]);
          compare_field("last", due.last, out_tlast);
        end
      end
    end
    tags_pending = tags_due.size();
  end

endmodule

[verif/tb_irc_message_field_tagger.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_irc_message_field_tagger
// Feeds the field tagger a short directed set of lines, then random IRC
// messages (prefixes, commands, long parameter lists, trailing parameters,
// odd whitespace, missing line ends) mixed with raw noise, under random
// gaps and stalls on both streams. The checker module does all comparing.
// ----------------------------------------------------------------------------
module tb_irc_message_field_tagger;
  import irc_mft_pkg::*;

  localparam int BYTE_TARGET  = 1650;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  int         tags_pending;
  int         mismatch_count;
  int         cycle_count = 0;
  int         bytes_sent  = 0;
  bit         quiet_in    = 1'b0;
  logic [7:0] msg_bytes[$];

  irc_message_field_tagger u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  irc_field_tag_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .tags_pending   (tags_pending),
    .mismatch_count (mismatch_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_irc_message_field_tagger: done, errors");
      $finish;
    end
  end

  function automatic bit is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  // Content byte: separators often, otherwise any non-blank value
  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = CH_COLON;
      1: b = CH_BANG;
      2: b = CH_AT;
      default: begin
        do b = 8'($urandom_range(0, 255)); while (is_blank(b));
      end
    endcase
    return b;
  endfunction

  // Append one byte to the message being built
  task automatic add_byte(input logic [7:0] b);
    msg_bytes.insert(msg_bytes.size(), b);
  endtask

  task automatic add_word(input int len_max);
    repeat ($urandom_range(1, len_max)) add_byte(word_byte());
  endtask

  // Whitespace run; never CR then LF, so it cannot end the line
  task automatic add_gap();
    logic [7:0] b;
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 9))
        0:       b = CH_TAB;
        1:       b = CH_VT;
        2:       b = CH_FF;
        3:       b = CH_CR;
        4:       b = CH_LF;
        default: b = CH_SPACE;
      endcase
      if (b == CH_LF && msg_bytes.size() > 0 && msg_bytes[$] == CH_CR) begin
        b = CH_SPACE;
      end
      add_byte(b);
    end
  endtask

  // One byte per transfer, with a random hold-off before it
  task automatic send_rx_byte(input logic [7:0] b);
    int gap;
    bit taken;
    gap = quiet_in ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    bytes_sent++;
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) send_rx_byte(msg_bytes[i]);
  endtask

  // Hold the input until every tag due has come out
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (tags_pending != 0);
    @(posedge clk);
  endtask

  // Result side: random stall before each transfer, quiet stretches now and then
  initial begin
    int stall;
    bit taken;
    bit quiet_out;
    quiet_out = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) quiet_out = !quiet_out;
      stall = quiet_out ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        taken = out_tvalid;
        @(posedge clk);
      end while (!taken);
    end
  end

  initial begin
    int n_params;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty line, then a full line with a prefix of all three parts,
    // a colon-led command, a colon inside a middle word, a trailing parameter
    // with a lone CR, a lone LF and mixed blanks, and blanks before the line end
    msg_bytes = '{CH_CR, CH_LF,
                  CH_SPACE, CH_COLON, 8'hFF, CH_BANG, 8'h00, CH_AT, "h", CH_SPACE,
                  CH_COLON, "C", CH_TAB, "m", CH_COLON, CH_SPACE, CH_COLON, "t",
                  CH_CR, "u", CH_LF, CH_VT, "v", CH_SPACE, CH_CR, CH_LF};
    send_message();
    wait_for_drain();

    // Random messages, mostly well formed, some raw noise
    while (bytes_sent < BYTE_TARGET) begin
      if ($urandom_range(0, 9) == 0) wait_for_drain();
      quiet_in = ($urandom_range(0, 3) == 0);
      msg_bytes.delete();
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 24)) begin
          case ($urandom_range(0, 7))
            0:       add_byte(CH_CR);
            1:       add_byte(CH_LF);
            2:       add_byte(CH_COLON);
            3:       add_byte(CH_SPACE);
            default: add_byte(8'($urandom_range(0, 255)));
          endcase
        end
        if ($urandom_range(0, 1) == 0) begin
          add_byte(CH_CR);
          add_byte(CH_LF);
        end
      end else begin
        if ($urandom_range(0, 3) == 0) add_gap();
        // prefix, then sometimes a command that starts with a colon
        if ($urandom_range(0, 1) == 1) begin
          add_byte(CH_COLON);
          add_word(4);
          if ($urandom_range(0, 1) == 1) begin
            add_byte(CH_BANG);
            add_word(4);
          end
          if ($urandom_range(0, 1) == 1) begin
            add_byte(CH_AT);
            add_word(6);
          end
          if ($urandom_range(0, 7) == 0) begin
            add_byte(CH_COLON);
            add_word(3);
          end
          add_gap();
          if ($urandom_range(0, 5) == 0) add_byte(CH_COLON);
        end
        add_word(5);
        // long lists push the parameter index into saturation
        n_params = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20)
                                               : $urandom_range(0, 4);
        for (int i = 0; i < n_params; i++) begin
          add_gap();
          if (i == n_params - 1 && $urandom_range(0, 1) == 1) begin
            add_byte(CH_COLON);
            repeat ($urandom_range(0, 3)) begin
              if ($urandom_range(0, 1) == 1) add_gap();
              add_word(5);
            end
            if ($urandom_range(0, 2) == 0) add_gap();
          end else begin
            add_word(4);
          end
        end
        // usually CRLF; sometimes blanks first, sometimes no line end at all
        case ($urandom_range(0, 19))
          0: begin
          end
          1, 2: begin
            add_gap();
            add_byte(CH_CR);
            add_byte(CH_LF);
          end
          default: begin
            add_byte(CH_CR);
            add_byte(CH_LF);
          end
        endcase
      end
      send_message();
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && tags_pending == 0) begin
      $display("tb_irc_message_field_tagger: done, clean");
    end else begin
      $display("tb_irc_message_field_tagger: done, errors");
    end
    $finish;
  end

endmodule
